FILE: design/elg_pkg.sv
// ----------------------------------------------------------------------------
// ElGamal engine package
// Shared constants and payload types of the ElGamal engine.
// ----------------------------------------------------------------------------
package elg_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FIELD_BITS    = 32;
    localparam int CFG_IDX_BITS  = 2;

    // Register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GENERATOR = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PUBLIC    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PRIVATE   = 2'd3;

    // Operation kinds.
    localparam logic KIND_ENCRYPT = 1'b0;
    localparam logic KIND_DECRYPT = 1'b1;

    localparam logic [31:0] MODULUS_RESET   = 32'd4294967291;
    localparam logic [31:0] GENERATOR_RESET = 32'd2;
    localparam logic [31:0] PUBLIC_RESET    = 32'd1;
    localparam logic [31:0] PRIVATE_RESET   = 32'd1;

    typedef struct packed {
        logic        kind;
        logic [31:0] nonce;
        logic [31:0] message;
        logic [31:0] cipher_first;
        logic [31:0] cipher_second;
    } t_in_item;

    typedef struct packed {
        logic [31:0] value_first;
        logic [31:0] value_second;
    } t_out_item;

    // Handshake between the sequencer and the modular multiplier.
    typedef struct packed {
        logic start;
    } t_mul_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

FILE: design/elg_modmul.sv
// ----------------------------------------------------------------------------
// Modular multiplier
// Shift-and-add multiplier reducing mod p one operand bit per cycle.
// ----------------------------------------------------------------------------
module elg_modmul #(
    parameter int WORD_BITS = elg_pkg::WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  elg_pkg::t_mul_req    i_req,
    input  logic [WORD_BITS-1:0] i_a,
    input  logic [WORD_BITS-1:0] i_b,
    input  logic [WORD_BITS-1:0] i_p,
    output elg_pkg::t_mul_stat   o_stat,
    output logic [WORD_BITS-1:0] o_prod
);
    localparam int CNT_BITS = $clog2(WORD_BITS + 1);
    localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(WORD_BITS - 1);

    logic                 r_busy, r_done, r_red;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [WORD_BITS-1:0] r_acc, r_a, r_b, r_sh;
    logic [WORD_BITS:0]   dbl, dbl_r, add, add_r;

    // Doubling then conditional addition, each reduced by one subtract.
    always_comb begin
        dbl   = {r_acc, 1'b0};
        dbl_r = (dbl >= {1'b0, i_p}) ? dbl - {1'b0, i_p} : dbl;
        add   = dbl_r + {1'b0, r_a};
        if (!r_sh[WORD_BITS-1]) begin
            add = dbl_r;
        end
        add_r = (add >= {1'b0, i_p}) ? add - {1'b0, i_p} : add;
    end

    // An operand a that is not below p is first reduced by running the same
    // datapath over its bits with an addend of one.
    // The product then takes one bit of b per cycle, most significant first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_b    <= i_b;
                if (i_a >= i_p) begin
                    r_red <= 1'b1;
                    r_a   <= WORD_BITS'(1);
                    r_sh  <= i_a;
                end else begin
                    r_red <= 1'b0;
                    r_a   <= i_a;
                    r_sh  <= i_b;
                end
            end else if (r_busy && r_red && r_cnt == LAST) begin
                // Operand a is now reduced: start the product proper.
                r_red <= 1'b0;
                r_a   <= add_r[WORD_BITS-1:0];
                r_sh  <= r_b;
                r_acc <= '0;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_acc <= add_r[WORD_BITS-1:0];
                r_sh  <= {r_sh[WORD_BITS-2:0], 1'b0};
                r_cnt <= r_cnt + CNT_BITS'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = r_acc;
endmodule

FILE: design/elgamal_encrypt_decrypt.sv
// ----------------------------------------------------------------------------
// ElGamal encrypt / decrypt engine
// Square-and-multiply exponentiation over a configurable prime modulus.
// ----------------------------------------------------------------------------
// One item is taken at a time. The shared shift-and-add multiplier first
// reduces its first operand when that is not yet below p, which happens
// only on the first square of a fresh base. An exponentiation walks the
// exponent up to its top set bit: a set bit costs a multiply and a square,
// a clear bit a square only. An encrypt runs two powers of the nonce and one
// final product, a decrypt a power of the private key, a power of p-2 and one
// final product. The result is held in an output register until taken; a new
// item is accepted only once it has been delivered.
module elgamal_encrypt_decrypt #(
    parameter int WORD_BITS = elg_pkg::WORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [elg_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [elg_pkg::FIELD_BITS-1:0]       i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  elg_pkg::t_in_item                    i_item,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output elg_pkg::t_out_item                   o_item
);
    localparam int W = WORD_BITS;
    localparam int EC = $clog2(W + 1);

    localparam logic [3:0] S_IDLE = 4'd0, S_POW = 4'd1, S_SQR = 4'd2,
                           S_FIN = 4'd3, S_WAIT = 4'd5;
    // Phase codes of the item.
    localparam logic [2:0] P_ENC1 = 3'd0, P_ENC2 = 3'd1, P_ENC3 = 3'd2,
                           P_DEC1 = 3'd3, P_DEC2 = 3'd4, P_DEC3 = 3'd5;

    logic [W-1:0] r_mod, r_gen, r_pub, r_priv;
    logic [3:0]   r_state;
    logic [2:0]   r_phase;
    logic [W-1:0] r_acc, r_base, r_exp, r_first, r_msg, r_nonce;
    logic [EC-1:0] r_ecnt;
    logic         r_ovalid;
    elg_pkg::t_out_item r_out;

    elg_pkg::t_mul_req  mreq;
    elg_pkg::t_mul_stat mstat;
    logic [W-1:0] ma, mb, mprod;
    logic [W-1:0] one_p;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod  <= elg_pkg::MODULUS_RESET[W-1:0];
            r_gen  <= elg_pkg::GENERATOR_RESET[W-1:0];
            r_pub  <= elg_pkg::PUBLIC_RESET[W-1:0];
            r_priv <= elg_pkg::PRIVATE_RESET[W-1:0];
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                elg_pkg::REG_MODULUS:   r_mod  <= i_cfg_data[W-1:0];
                elg_pkg::REG_GENERATOR: r_gen  <= i_cfg_data[W-1:0];
                elg_pkg::REG_PUBLIC:    r_pub  <= i_cfg_data[W-1:0];
                default:                r_priv <= i_cfg_data[W-1:0];
            endcase
        end
    end

    assign one_p = (r_mod == W'(1)) ? '0 : W'(1);

    elg_modmul #(.WORD_BITS(W)) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mreq),
        .i_a    (ma),
        .i_b    (mb),
        .i_p    (r_mod),
        .o_stat (mstat),
        .o_prod (mprod)
    );

    // Operand selection: multiply step, square step or final product.
    always_comb begin
        ma = r_acc;
        mb = r_base;
        unique case (r_state)
            S_SQR:   ma = r_base;
            S_FIN:   mb = r_msg;
            default: ma = r_acc;
        endcase
    end

    logic n_start;
    assign mreq.start = n_start;

    // Sequencer: one exponent bit is a conditional multiply then a square.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !r_ovalid) begin
                        r_acc   <= one_p;
                        r_ecnt  <= '0;
                        r_nonce <= i_item.nonce[W-1:0];
                        if (r_mod < W'(2)) begin
                            r_out    <= '0;
                            r_ovalid <= 1'b1;
                        end else if (i_item.kind == elg_pkg::KIND_ENCRYPT) begin
                            r_phase <= P_ENC1;
                            r_base  <= r_gen;
                            r_exp   <= i_item.nonce[W-1:0];
                            r_msg   <= i_item.message[W-1:0];
                            r_state <= S_POW;
                        end else begin
                            r_phase <= P_DEC1;
                            r_base  <= i_item.cipher_first[W-1:0];
                            r_exp   <= r_priv;
                            r_msg   <= i_item.cipher_second[W-1:0];
                            r_state <= S_POW;
                        end
                    end
                end
                S_POW: begin
                    if (r_exp == '0) begin
                        // Power done: move to the next phase.
                        unique case (r_phase)
                            P_ENC1: begin
                                r_first <= r_acc;
                                r_acc   <= one_p;
                                r_base  <= r_pub;
                                r_exp   <= r_nonce;
                                r_phase <= P_ENC2;
                            end
                            P_ENC2: begin
                                r_state <= S_FIN;
                                r_phase <= P_ENC3;
                            end
                            P_DEC1: begin
                                r_acc   <= one_p;
                                r_base  <= r_acc;
                                r_exp   <= r_mod - W'(2);
                                r_phase <= P_DEC2;
                            end
                            default: begin
                                r_state <= S_FIN;
                                r_phase <= P_DEC3;
                            end
                        endcase
                    end else if (r_exp[0]) begin
                        r_state <= S_WAIT;
                        r_ecnt  <= EC'(1);
                    end else begin
                        r_state <= S_SQR;
                        r_ecnt  <= EC'(2);
                    end
                end
                S_SQR: r_state <= S_WAIT;
                S_FIN: r_state <= S_WAIT;
                S_WAIT: begin
                    if (mstat.done) begin
                        if (r_phase == P_ENC3 || r_phase == P_DEC3) begin
                            r_out.value_first  <= (r_phase == P_ENC3) ?
                                elg_pkg::FIELD_BITS'(r_first) :
                                elg_pkg::FIELD_BITS'(mprod);
                            r_out.value_second <= (r_phase == P_ENC3) ?
                                elg_pkg::FIELD_BITS'(mprod) : '0;
                            r_ovalid <= 1'b1;
                            r_state  <= S_IDLE;
                        end else if (r_ecnt == EC'(1)) begin
                            r_acc   <= mprod;
                            r_ecnt  <= EC'(2);
                            r_state <= S_SQR;
                        end else begin
                            r_base  <= mprod;
                            r_exp   <= r_exp >> 1;
                            r_state <= S_POW;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Start pulses: a multiply in S_POW on a set exponent bit, squares, finals.
    always_comb begin
        n_start = 1'b0;
        if (r_state == S_POW && r_exp[0]) begin
            n_start = 1'b1;
        end
        if (r_state == S_SQR || r_state == S_FIN) n_start = 1'b1;
    end

    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    // The multiplier is started only when it is free.
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mreq.start |-> !mstat.busy) else $error("multiplier restarted busy");
    // No item is accepted while a result waits.
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> o_stall) else $error("accept while result pending");
    // A result stays until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_item)))
        else $error("result dropped");
endmodule

FILE: tb/sv/elgamal_encrypt_decrypt_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ElGamal engine testbench
// Drives encrypt and decrypt items through the engine under several modulus
// and key settings, predicts each result with a shadow square-and-multiply
// model and compares every delivered result field by field.
// ----------------------------------------------------------------------------
module elgamal_encrypt_decrypt_tb;

    localparam int WATCHDOG_LIMIT = 100000;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [elg_pkg::CFG_IDX_BITS-1:0] i_cfg_idx = elg_pkg::REG_MODULUS;
    logic [elg_pkg::FIELD_BITS-1:0]   i_cfg_data = '0;
    logic                             i_valid = 1'b0;
    logic                             o_stall;
    elg_pkg::t_in_item                i_item = '0;
    logic                             o_valid;
    logic                             i_stall = 1'b0;
    elg_pkg::t_out_item               o_item;

    // Shadow copies of the engine registers.
    logic [31:0] sh_modulus = elg_pkg::MODULUS_RESET;
    logic [31:0] sh_generator = elg_pkg::GENERATOR_RESET;
    logic [31:0] sh_public = elg_pkg::PUBLIC_RESET;
    logic [31:0] sh_private = elg_pkg::PRIVATE_RESET;

    elg_pkg::t_in_item  pending_items[$];
    elg_pkg::t_out_item expected_results[$];

    int  send_gap = 0;
    int  take_gap = 0;
    bit  quiet = 1'b0;
    int  mismatches = 0;
    int  checked = 0;
    int  n_encrypt = 0;
    int  n_decrypt = 0;
    int  n_cfg = 0;
    int  idle_cycles = 0;

    elgamal_encrypt_decrypt dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (i_item),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_item    (o_item)
    );

    always #10 i_clk = ~i_clk;

    // Modular product; operands stay below 2^32 so the product fits 64 bits.
    function automatic longint unsigned mod_product(longint unsigned a, longint unsigned b,
                                                    longint unsigned p);
        return ((a % p) * (b % p)) % p;
    endfunction

    // Right-to-left square-and-multiply.
    function automatic longint unsigned mod_power(longint unsigned base, longint unsigned e,
                                                  longint unsigned p);
        longint unsigned acc;
        longint unsigned b;
        acc = 1 % p;
        b = base % p;
        while (e != 0) begin
            if (e[0]) acc = mod_product(acc, b, p);
            b = mod_product(b, b, p);
            e = e >> 1;
        end
        return acc;
    endfunction

    // Expected result of one item under the current register settings.
    function automatic elg_pkg::t_out_item elgamal_result(elg_pkg::t_in_item it);
        elg_pkg::t_out_item r;
        longint unsigned    p;
        longint unsigned    shared;
        longint unsigned    inv;
        r = '0;
        p = sh_modulus;
        if (p >= 2) begin
            if (it.kind == elg_pkg::KIND_ENCRYPT) begin
                r.value_first = 32'(mod_power(sh_generator, it.nonce, p));
                r.value_second = 32'(mod_product(mod_power(sh_public, it.nonce, p),
                                                 it.message, p));
            end else begin
                shared = mod_power(it.cipher_first, sh_private, p);
                inv = mod_power(shared, p - 2, p);
                r.value_first = 32'(mod_product(it.cipher_second, inv, p));
            end
        end
        return r;
    endfunction

    // Appends one item to the pending queue.
    task automatic add_item(elg_pkg::t_in_item it);
        pending_items = {pending_items, it};
    endtask

    // Item driver: takes items from the pending queue, with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_results = {expected_results, elgamal_result(i_item)};
                if (i_item.kind == elg_pkg::KIND_ENCRYPT) n_encrypt++;
                else n_decrypt++;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0 && !quiet &&
                             $urandom_range(0, 3) == 0) begin
                    send_gap <= $urandom_range(0, 7);
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    i_valid <= 1'b1;
                    i_item <= pending_items.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random stall bursts and comparison with the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            take_gap <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h %h", o_item.value_first,
                                 o_item.value_second);
                end else begin
                    elg_pkg::t_out_item want;
                    want = expected_results.pop_front();
                    checked++;
                    if (want.value_first !== o_item.value_first ||
                        want.value_second !== o_item.value_second) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h %h, got %h %h",
                                     want.value_first, want.value_second,
                                     o_item.value_first, o_item.value_second);
                    end
                end
            end
            if (take_gap > 0) begin
                take_gap <= take_gap - 1;
                i_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                take_gap <= $urandom_range(0, 7);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles in which nothing is accepted.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(logic [elg_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_cfg++;
        case (idx)
            elg_pkg::REG_MODULUS:   sh_modulus = val;
            elg_pkg::REG_GENERATOR: sh_generator = val;
            elg_pkg::REG_PUBLIC:    sh_public = val;
            elg_pkg::REG_PRIVATE:   sh_private = val;
        endcase
    endtask

    task automatic set_keys(logic [31:0] p, logic [31:0] g, logic [31:0] y, logic [31:0] x);
        write_reg(elg_pkg::REG_MODULUS, p);
        write_reg(elg_pkg::REG_GENERATOR, g);
        write_reg(elg_pkg::REG_PUBLIC, y);
        write_reg(elg_pkg::REG_PRIVATE, x);
    endtask

    // Wait until every queued item has gone through and its result arrived.
    // The check is made between edges, once the driver and monitor have settled.
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_items.size() > 0 || i_valid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic elg_pkg::t_in_item make_item(logic kind, logic [31:0] r,
                                                    logic [31:0] m, logic [31:0] c1,
                                                    logic [31:0] c2);
        elg_pkg::t_in_item it;
        it.kind = kind;
        it.nonce = r;
        it.message = m;
        it.cipher_first = c1;
        it.cipher_second = c2;
        return it;
    endfunction

    // Mostly encrypt-then-decrypt pairs of the same message, with some raw noise.
    task automatic queue_random(int count);
        elg_pkg::t_in_item  enc;
        elg_pkg::t_out_item ct;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                add_item(make_item(1'($urandom_range(0, 1)), $urandom,
                                   $urandom, $urandom, $urandom));
            end else begin
                enc = make_item(elg_pkg::KIND_ENCRYPT, $urandom, $urandom % sh_modulus,
                                $urandom, $urandom);
                ct = elgamal_result(enc);
                add_item(enc);
                add_item(make_item(elg_pkg::KIND_DECRYPT, $urandom, $urandom,
                                   ct.value_first, ct.value_second));
                k++;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: extremes of nonce, message and ciphertext.
        add_item(make_item(elg_pkg::KIND_ENCRYPT, '0, 32'd5, '0, '0));
        add_item(make_item(elg_pkg::KIND_ENCRYPT, '1, '1, '1, '1));
        add_item(make_item(elg_pkg::KIND_ENCRYPT, 32'd1, '0, '0, '0));
        add_item(make_item(elg_pkg::KIND_DECRYPT, '1, '1, '0, 32'd77));
        add_item(make_item(elg_pkg::KIND_DECRYPT, '0, '0, elg_pkg::MODULUS_RESET, '1));
        add_item(make_item(elg_pkg::KIND_DECRYPT, '0, '0, '1, '1));
        wait_drained();

        // Modulus two: the inverse exponent is zero.
        set_keys(32'd2, '1, '1, '1);
        add_item(make_item(elg_pkg::KIND_ENCRYPT, '1, '1, '0, '0));
        add_item(make_item(elg_pkg::KIND_DECRYPT, '0, '0, 32'd3, 32'd5));
        add_item(make_item(elg_pkg::KIND_DECRYPT, '0, '0, 32'd4, 32'd5));
        wait_drained();

        // Modulus zero and one give all-zero results.
        write_reg(elg_pkg::REG_MODULUS, '0);
        add_item(make_item(elg_pkg::KIND_ENCRYPT, '1, '1, '1, '1));
        add_item(make_item(elg_pkg::KIND_DECRYPT, '1, '1, '1, '1));
        wait_drained();
        write_reg(elg_pkg::REG_MODULUS, 32'd1);
        add_item(make_item(elg_pkg::KIND_ENCRYPT, 32'd7, 32'd9, '0, '0));
        add_item(make_item(elg_pkg::KIND_DECRYPT, '0, '0, 32'd7, 32'd9));
        wait_drained();

        // Zero private key: zero ciphertext head gives c2 mod p.
        set_keys(32'd65521, '0, '0, '0);
        add_item(make_item(elg_pkg::KIND_DECRYPT, '0, '0, '0, '1));
        add_item(make_item(elg_pkg::KIND_ENCRYPT, 32'd3, '1, '0, '0));
        add_item(make_item(elg_pkg::KIND_ENCRYPT, '0, '1, '0, '0));
        wait_drained();

        // Smallest odd prime, then random traffic under a small prime.
        set_keys(32'd3, 32'd2, 32'd2, 32'd1);
        add_item(make_item(elg_pkg::KIND_DECRYPT, '0, '0, 32'd6, '1));
        add_item(make_item(elg_pkg::KIND_ENCRYPT, '1, 32'd4, '0, '0));
        wait_drained();
        set_keys(32'd65521, $urandom, $urandom, $urandom);
        queue_random(20);
        wait_drained();

        // Composite modulus with random keys.
        set_keys(32'd1000000, $urandom, $urandom, $urandom);
        queue_random(16);
        wait_drained();

        // Largest modulus, which is composite.
        set_keys('1, '1, $urandom, '1);
        add_item(make_item(elg_pkg::KIND_DECRYPT, '0, '0, '0, '1));
        queue_random(14);
        wait_drained();

        // Largest 32-bit prime with random keys.
        set_keys(elg_pkg::MODULUS_RESET, $urandom, $urandom, $urandom);
        queue_random(30);
        wait_drained();

        // Final stretch without any idling on either side.
        quiet = 1'b1;
        set_keys(32'd4294967029, $urandom, $urandom, $urandom);
        queue_random(20);
        wait_drained();
        repeat (50) @(posedge i_clk);

        $display("covered %0d encrypt and %0d decrypt items, %0d register writes",
                 n_encrypt, n_decrypt, n_cfg);
        $display("%0d results checked, %0d mismatches", checked, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
